FILE: rtl/core/gnss_nmea_rtcm3_deframer_unit_macros.svh
// ---------------------------------------------------------------------------
// gnss deframer assertion macros
// shared assertion shorthands for the deframer rtl, clocked on clk with
// the synchronous active-low reset as disable
// ---------------------------------------------------------------------------
`ifndef GNSS_NMEA_RTCM3_DEFRAMER_UNIT_MACROS_SVH
`define GNSS_NMEA_RTCM3_DEFRAMER_UNIT_MACROS_SVH

// same-cycle implication
`define GND_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// next-cycle implication
`define GND_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

FILE: rtl/core/gnd_pkg.sv
// ---------------------------------------------------------------------------
// gnd_pkg
// shared types, codes and the crc-24q byte update for the gnss deframer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package gnd_pkg;

  localparam int BUFFER_BYTES = 1024;
  localparam int LEN_W        = 11;
  localparam int PLEN_W       = 10;
  localparam int CRC_W        = 24;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 11'd1024;

  localparam logic [CRC_W:0]   CRC_POLY = 25'h1864CFB;

  localparam logic [7:0] NMEA_START = 8'h24;
  localparam logic [7:0] RTCM_START = 8'hD3;
  localparam logic [7:0] RSVD_MASK  = 8'hFC;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  // rtcm3 framing overhead: preamble, two header bytes, three crc bytes
  localparam logic [LEN_W-1:0] RTCM_HDR   = 11'd3;
  localparam logic [LEN_W-1:0] RTCM_LAST  = 11'd5;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_CRC  = 2'd1,
    ST_RSVD = 2'd2,
    ST_LONG = 2'd3
  } status_t;

  typedef enum logic {
    KIND_NMEA = 1'b0,
    KIND_RTCM = 1'b1
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    kind_t      frame_kind;
    logic       last_byte;
    status_t    frame_status;
  } beat_t;

  // bytewise crc-24q, msb first, eight shift steps
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [7:0] b);
    logic [CRC_W:0] c;
    c = {1'b0, crc ^ {b, 16'h0000}};
    for (int i = 0; i < 8; i++) begin
      c = {c[CRC_W-1:0], 1'b0};
      if (c[CRC_W]) begin
        c = c ^ CRC_POLY;
      end
    end
    return c[CRC_W-1:0];
  endfunction

endpackage

FILE: rtl/core/gnss_nmea_rtcm3_deframer_unit.sv
// ---------------------------------------------------------------------------
// gnss_nmea_rtcm3_deframer_unit
// splits a gnss receiver byte stream into tagged nmea and rtcm3 frames
// ---------------------------------------------------------------------------
// Takes one receiver byte per cycle while in_ready is high and emits every
// frame byte tagged with its kind, a last flag and, on the last byte, a
// status (ok, crc mismatch, reserved bits nonzero, too long); bytes between
// frames are dropped. The parser handles one byte per cycle, limited by the
// combinational bytewise crc-24q update; a four-beat queue and an output
// register follow, which each result passes through in turn, and in_ready
// drops only when the queue is full. The frame length limit is
// min(cfg_max_frame_len, 1024) and resets to 1024; write it only while idle.
`timescale 1ns / 1ps

module gnss_nmea_rtcm3_deframer_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_rx_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_data_byte,
  output logic                      out_frame_kind,
  output logic                      out_last_byte,
  output logic [1:0]                out_frame_status,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [gnd_pkg::LEN_W-1:0] cfg_max_frame_len
);

  logic           in_fire;
  logic           push, pop, q_full, q_valid;
  gnd_pkg::beat_t parse_beat, q_beat, out_beat;

  assign in_ready  = !q_full;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  gnd_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .rx_byte  (in_rx_byte),
    .cfg_we   (cfg_valid),
    .cfg_data (cfg_max_frame_len),
    .push     (push),
    .beat     (parse_beat)
  );

  gnd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_beat  (parse_beat),
    .pop      (pop),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_beat  (q_beat)
  );

  gnd_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_beat    (q_beat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

  assign out_data_byte    = out_beat.data_byte;
  assign out_frame_kind   = out_beat.frame_kind;
  assign out_last_byte    = out_beat.last_byte;
  assign out_frame_status = out_beat.frame_status;

endmodule

FILE: rtl/core/gnd_parse.sv
// ---------------------------------------------------------------------------
// gnd_parse
// front end: hunts for frame starts, tracks nmea and rtcm3 framing, runs
// crc-24q and tags each frame byte with kind, last flag and status
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gnd_parse (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_fire,
  input  logic [7:0]                rx_byte,
  input  logic                      cfg_we,
  input  logic [gnd_pkg::LEN_W-1:0] cfg_data,
  output logic                      push,
  output gnd_pkg::beat_t            beat
);

  typedef enum logic [1:0] {
    M_HUNT = 2'd0,
    M_NMEA = 2'd1,
    M_RTCM = 2'd2
  } mode_t;

  mode_t                        mode_r, mode_nxt, mode_eff;
  logic [gnd_pkg::LEN_W-1:0]    cnt_r, cnt_nxt;
  logic [gnd_pkg::PLEN_W-1:0]   plen_r, plen_nxt;
  logic [gnd_pkg::CRC_W-1:0]    crc_r, crc_nxt;
  logic [gnd_pkg::CRC_W-1:0]    rcrc_r, rcrc_nxt;
  logic                         prev_cr_r, prev_cr_nxt;
  logic [gnd_pkg::LEN_W-1:0]    max_len_r, max_len_nxt;

  logic                         hunting;
  logic [gnd_pkg::LEN_W-1:0]    k;
  logic [gnd_pkg::LEN_W:0]      k1;
  logic [gnd_pkg::PLEN_W-1:0]   plen_w;
  logic [gnd_pkg::CRC_W-1:0]    crc_in, crc_w, rcrc_in, rcrc_w;
  logic [gnd_pkg::LEN_W-1:0]    limit;
  logic                         done;
  gnd_pkg::status_t             status;
  gnd_pkg::kind_t               kind;

  assign limit = (max_len_r < gnd_pkg::LEN_W'(gnd_pkg::BUFFER_BYTES)) ?
                 max_len_r : gnd_pkg::LEN_W'(gnd_pkg::BUFFER_BYTES);

  always_comb begin
    hunting     = (mode_r != M_NMEA) && (mode_r != M_RTCM);
    mode_nxt    = mode_r;
    cnt_nxt     = cnt_r;
    plen_nxt    = plen_r;
    crc_nxt     = crc_r;
    rcrc_nxt    = rcrc_r;
    prev_cr_nxt = prev_cr_r;
    max_len_nxt = cfg_we ? cfg_data : max_len_r;
    push        = 1'b0;
    done        = 1'b0;
    status      = gnd_pkg::ST_OK;
    kind        = gnd_pkg::KIND_NMEA;

    if (hunting) begin
      if (rx_byte == gnd_pkg::NMEA_START) begin
        mode_eff = M_NMEA;
      end else if (rx_byte == gnd_pkg::RTCM_START) begin
        mode_eff = M_RTCM;
      end else begin
        mode_eff = M_HUNT;
      end
    end else begin
      mode_eff = mode_r;
    end

    // a new frame sees cleared counters and crc
    k       = hunting ? '0 : cnt_r;
    crc_in  = hunting ? '0 : crc_r;
    rcrc_in = hunting ? '0 : rcrc_r;
    plen_w  = hunting ? '0 : plen_r;
    crc_w   = crc_in;
    rcrc_w  = rcrc_in;
    k1      = {1'b0, k} + (gnd_pkg::LEN_W+1)'(1);

    if (in_fire && mode_eff != M_HUNT) begin
      push = 1'b1;
      if (mode_eff == M_NMEA) begin
        kind = gnd_pkg::KIND_NMEA;
        if (!hunting && prev_cr_r && rx_byte == gnd_pkg::CHAR_LF) begin
          done = 1'b1;
        end
        prev_cr_nxt = (rx_byte == gnd_pkg::CHAR_CR);
      end else begin
        kind = gnd_pkg::KIND_RTCM;
        if (k == gnd_pkg::LEN_W'(1)) begin
          if ((rx_byte & gnd_pkg::RSVD_MASK) != 8'h00) begin
            done   = 1'b1;
            status = gnd_pkg::ST_RSVD;
          end else begin
            plen_w = {rx_byte[1:0], 8'h00};
          end
        end else if (k == gnd_pkg::LEN_W'(2)) begin
          plen_w = {plen_w[9:8], rx_byte};
        end
        if (!done) begin
          if (k < {1'b0, plen_w} + gnd_pkg::RTCM_HDR) begin
            crc_w = gnd_pkg::crc_byte(crc_in, rx_byte);
          end else begin
            rcrc_w = {rcrc_in[15:0], rx_byte};
            if (k >= {1'b0, plen_w} + gnd_pkg::RTCM_LAST) begin
              done   = 1'b1;
              status = (rcrc_w == crc_in) ? gnd_pkg::ST_OK : gnd_pkg::ST_CRC;
            end
          end
        end
        plen_nxt = plen_w;
        crc_nxt  = crc_w;
        rcrc_nxt = rcrc_w;
      end
      cnt_nxt = k1[gnd_pkg::LEN_W-1:0];
      if (!done && k1 >= {1'b0, limit}) begin
        done   = 1'b1;
        status = gnd_pkg::ST_LONG;
      end
      mode_nxt = done ? M_HUNT : mode_eff;
    end

    beat.data_byte    = rx_byte;
    beat.frame_kind   = kind;
    beat.last_byte    = done;
    beat.frame_status = done ? status : gnd_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_HUNT;
      cnt_r     <= '0;
      plen_r    <= '0;
      crc_r     <= '0;
      rcrc_r    <= '0;
      prev_cr_r <= 1'b0;
      max_len_r <= gnd_pkg::MAX_LEN_RESET;
    end else begin
      mode_r    <= mode_nxt;
      cnt_r     <= cnt_nxt;
      plen_r    <= plen_nxt;
      crc_r     <= crc_nxt;
      rcrc_r    <= rcrc_nxt;
      prev_cr_r <= prev_cr_nxt;
      max_len_r <= max_len_nxt;
    end
  end

endmodule

FILE: rtl/core/gnd_fifo.sv
// ---------------------------------------------------------------------------
// gnd_fifo
// short queue of tagged beats between the parser and the output stage
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "gnss_nmea_rtcm3_deframer_unit_macros.svh"

module gnd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  gnd_pkg::beat_t wr_beat,
  input  logic           pop,
  output logic           full,
  output logic           rd_valid,
  output gnd_pkg::beat_t rd_beat
);

  gnd_pkg::beat_t                q_r [gnd_pkg::QDEPTH];
  logic [gnd_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [gnd_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [gnd_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;

  assign full     = (cnt_r == gnd_pkg::QCNT_W'(gnd_pkg::QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_beat  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + gnd_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + gnd_pkg::QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + gnd_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - gnd_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= wr_beat;
    end
  end

  `GND_ASSERT_IMP(a_no_overflow, push, !full)
  `GND_ASSERT_IMP(a_no_underflow, pop, rd_valid)
  `GND_ASSERT_NXT(a_cnt_up, push && !pop, cnt_r == $past(cnt_r) + gnd_pkg::QCNT_W'(1))
  `GND_ASSERT_NXT(a_ptr_gap, 1'b1,
    wr_ptr_r - rd_ptr_r == cnt_r[gnd_pkg::QPTR_W-1:0])

endmodule

FILE: rtl/core/gnd_out.sv
// ---------------------------------------------------------------------------
// gnd_out
// back end: drains the queue into the registered result port
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gnd_out (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  gnd_pkg::beat_t q_beat,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output gnd_pkg::beat_t out_beat
);

  logic           valid_r, valid_nxt;
  gnd_pkg::beat_t beat_r;

  // refill whenever the register is empty or its beat leaves this cycle
  assign pop       = q_valid && (!valid_r || out_ready);
  assign valid_nxt = pop || (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign out_beat  = beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      beat_r <= q_beat;
    end
  end

endmodule
